// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property clocked on clk_i and off while in reset
`define LQDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define LQDF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/lqdf_pkg.sv =====
// types, constants and state codes of the linear plus quadratic damping force block
package lqdf_pkg;

  localparam int DOF       = 6;
  localparam int AXES      = 6;
  localparam int FRAC_BITS = 16;

  localparam int COEF_W  = 32;
  localparam int VEL_W   = 32;
  localparam int FORCE_W = 48;
  localparam int OPND_W  = 33;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int P1_W    = 64;
  localparam int ACC_W   = 100;
  localparam int SH_W    = ACC_W - 2 * FRAC_BITS;
  localparam int DOT_W   = 84;

  localparam int TBL_N  = DOF * DOF;
  localparam int TBL_AW = (TBL_N > 1) ? $clog2(TBL_N) : 1;
  localparam int AXIS_W = (DOF > 1) ? $clog2(DOF) : 1;

  typedef enum logic [1:0] {
    OP_WR_LIN  = 2'd0,
    OP_WR_QUAD = 2'd1,
    OP_EVAL    = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QMUL,
    ST_LMUL,
    ST_QLO,
    ST_QHI,
    ST_ACC,
    ST_SAT,
    ST_DLO,
    ST_DHI,
    ST_DACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic [2:0]                 row;
    logic [2:0]                 col;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [VEL_W-1:0]    vel_0;
    logic signed [VEL_W-1:0]    vel_1;
    logic signed [VEL_W-1:0]    vel_2;
    logic signed [VEL_W-1:0]    vel_3;
    logic signed [VEL_W-1:0]    vel_4;
    logic signed [VEL_W-1:0]    vel_5;
  } in_req_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0]  force_0;
    logic signed [FORCE_W-1:0]  force_1;
    logic signed [FORCE_W-1:0]  force_2;
    logic signed [FORCE_W-1:0]  force_3;
    logic signed [FORCE_W-1:0]  force_4;
    logic signed [FORCE_W-1:0]  force_5;
    logic                       dissipative;
  } out_rsp_t;

endpackage

// ===== rtl/lqdf_mul.sv =====
// shared signed 33x33 multiplier with registered product
module lqdf_mul (
  input  logic                                    clk_i,
  input  logic signed [lqdf_pkg::OPND_W-1:0]      a_i,
  input  logic signed [lqdf_pkg::OPND_W-1:0]      b_i,
  output logic signed [lqdf_pkg::PROD_W-1:0]      p_o
);
  import lqdf_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/linear_quadratic_damping_force.sv =====
// linear plus quadratic damping force top level: coefficient tables, sequencer and datapath
//
// Two DOF x DOF tables of signed Q16.16 coefficients (linear and quadratic) sit in
// on-chip memories that read back as zero until an entry is written. A write request
// leaves the block idle, and the next request is taken in the following cycle. An evaluate
// request brings six Q16.16 velocities and returns six saturated Q32.16 forces,
// force = (linear + quadratic*|v|) * v, plus a dissipation flag that is set when all
// velocities are zero or v.force is positive. All products go through one 33x33
// multiplier: four passes per coefficient pair (quadratic*|v|, linear*v and two halves
// of the 64x32 product), then for each axis a saturation step and two passes for the
// halves of the flag dot product. The result sits in an output register; a new request
// is taken while it waits.
module linear_quadratic_damping_force (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lqdf_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lqdf_pkg::out_rsp_t  out_rsp_o
);
  import lqdf_pkg::*;

  state_e state_q, state_d;

  logic [COEF_W-1:0] lin_mem  [TBL_N];
  logic [COEF_W-1:0] quad_mem [TBL_N];
  logic [TBL_N-1:0]  lin_vld_q, quad_vld_q;
  logic [COEF_W-1:0] lin_rd_q, quad_rd_q;
  logic              lin_rdv_q, quad_rdv_q;
  logic signed [COEF_W-1:0] lin_coef, quad_coef;

  logic              in_acc, wr_ok, lin_we, quad_we, eval_start;
  logic [TBL_AW-1:0] wr_addr;

  logic [AXIS_W-1:0] i_q, j_q;
  logic [TBL_AW-1:0] k_q;
  logic signed [VEL_W-1:0]   v_q [DOF];
  logic signed [VEL_W-1:0]   vin [AXES];
  logic signed [FORCE_W-1:0] f_q [DOF];
  logic signed [FORCE_W-1:0] f_all [AXES];
  logic              allzero_q, allzero_d;

  logic signed [P1_W-1:0]  p1_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [DOT_W-1:0] dot_q;

  logic signed [OPND_W-1:0] mul_a, mul_b, vj33, vabs33, vi33;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [VEL_W-1:0]  vj, vi;
  logic signed [FORCE_W-1:0] fi, f_sat;
  logic signed [SH_W-1:0]   sh;
  logic [SH_W-FORCE_W:0]    sh_hi;

  logic     out_valid_q, out_load;
  out_rsp_t out_rsp_q;

  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_ok      = (in_req_i.row < 3'(DOF)) && (in_req_i.col < 3'(DOF));
  assign lin_we     = in_acc && (in_req_i.opcode == OP_WR_LIN) && wr_ok;
  assign quad_we    = in_acc && (in_req_i.opcode == OP_WR_QUAD) && wr_ok;
  assign eval_start = in_acc && (in_req_i.opcode == OP_EVAL);
  assign wr_addr    = TBL_AW'(in_req_i.row * DOF + in_req_i.col);

  // coefficient memories
  always_ff @(posedge clk_i) begin
    if (lin_we) begin
      lin_mem[wr_addr] <= in_req_i.coef_value;
    end
    if (quad_we) begin
      quad_mem[wr_addr] <= in_req_i.coef_value;
    end
    lin_rd_q  <= lin_mem[k_q];
    quad_rd_q <= quad_mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_vld_q  <= '0;
      quad_vld_q <= '0;
      lin_rdv_q  <= 1'b0;
      quad_rdv_q <= 1'b0;
    end else begin
      if (lin_we) begin
        lin_vld_q[wr_addr] <= 1'b1;
      end
      if (quad_we) begin
        quad_vld_q[wr_addr] <= 1'b1;
      end
      lin_rdv_q  <= lin_vld_q[k_q];
      quad_rdv_q <= quad_vld_q[k_q];
    end
  end

  assign lin_coef  = lin_rdv_q  ? lin_rd_q  : '0;
  assign quad_coef = quad_rdv_q ? quad_rd_q : '0;

  // velocity capture and zero test
  always_comb begin
    vin[0] = in_req_i.vel_0;
    vin[1] = in_req_i.vel_1;
    vin[2] = in_req_i.vel_2;
    vin[3] = in_req_i.vel_3;
    vin[4] = in_req_i.vel_4;
    vin[5] = in_req_i.vel_5;
    allzero_d = 1'b1;
    for (int a = 0; a < DOF; a++) begin
      if (vin[a] != '0) begin
        allzero_d = 1'b0;
      end
    end
  end

  assign vj     = v_q[j_q];
  assign vi     = v_q[i_q];
  assign fi     = f_q[i_q];
  assign vj33   = OPND_W'(vj);
  assign vi33   = OPND_W'(vi);
  assign vabs33 = vj33[OPND_W-1] ? -vj33 : vj33;

  // floor shift and 48-bit saturation
  assign sh    = acc_q[ACC_W-1:2*FRAC_BITS];
  assign sh_hi = sh[SH_W-1:FORCE_W-1];
  always_comb begin
    if ((&sh_hi) || !(|sh_hi)) begin
      f_sat = sh[FORCE_W-1:0];
    end else if (sh[SH_W-1]) begin
      f_sat = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      f_sat = {1'b0, {(FORCE_W-1){1'b1}}};
    end
  end

  lqdf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (eval_start) begin
          state_d = ST_QMUL;
        end
      end
      ST_QMUL: state_d = ST_LMUL;
      ST_LMUL: state_d = ST_QLO;
      ST_QLO:  state_d = ST_QHI;
      ST_QHI:  state_d = ST_ACC;
      ST_ACC: begin
        state_d = (j_q == AXIS_W'(DOF - 1)) ? ST_SAT : ST_QMUL;
      end
      ST_SAT:  state_d = ST_DLO;
      ST_DLO:  state_d = ST_DHI;
      ST_DHI:  state_d = ST_DACC;
      ST_DACC: begin
        state_d = (i_q == AXIS_W'(DOF - 1)) ? ST_DONE : ST_QMUL;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_QMUL: begin
        mul_a = OPND_W'(quad_coef);
        mul_b = vabs33;
      end
      ST_LMUL: begin
        mul_a = OPND_W'(lin_coef);
        mul_b = vj33;
      end
      ST_QLO: begin
        mul_a = {1'b0, p1_q[31:0]};
        mul_b = vj33;
      end
      ST_QHI: begin
        mul_a = OPND_W'($signed(p1_q[P1_W-1:32]));
        mul_b = vj33;
      end
      ST_DLO: begin
        mul_a = vi33;
        mul_b = {1'b0, fi[31:0]};
      end
      ST_DHI: begin
        mul_a = vi33;
        mul_b = OPND_W'($signed(fi[FORCE_W-1:32]));
      end
      ST_DONE: out_load = !out_valid_q || out_ready_i;
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
        end
        ST_QHI: k_q <= (k_q == TBL_AW'(TBL_N - 1)) ? '0 : k_q + 1'b1;
        ST_ACC: j_q <= (j_q == AXIS_W'(DOF - 1)) ? '0 : j_q + 1'b1;
        ST_DACC: i_q <= (i_q == AXIS_W'(DOF - 1)) ? '0 : i_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (eval_start) begin
          for (int a = 0; a < DOF; a++) begin
            v_q[a] <= vin[a];
            f_q[a] <= '0;
          end
          allzero_q <= allzero_d;
          acc_q     <= '0;
          dot_q     <= '0;
        end
      end
      ST_LMUL: p1_q <= mul_p[P1_W-1:0];
      ST_QLO:  acc_q <= acc_q + (ACC_W'(mul_p) <<< FRAC_BITS);
      ST_QHI:  acc_q <= acc_q + ACC_W'(mul_p);
      ST_ACC:  acc_q <= acc_q + (ACC_W'(mul_p) <<< 32);
      ST_SAT: begin
        f_q[i_q] <= f_sat;
        acc_q    <= '0;
      end
      ST_DHI:  dot_q <= dot_q + DOT_W'(mul_p);
      ST_DACC: dot_q <= dot_q + (DOT_W'(mul_p) <<< 32);
      ST_DONE: begin
        if (out_load) begin
          out_rsp_q.force_0     <= f_all[0];
          out_rsp_q.force_1     <= f_all[1];
          out_rsp_q.force_2     <= f_all[2];
          out_rsp_q.force_3     <= f_all[3];
          out_rsp_q.force_4     <= f_all[4];
          out_rsp_q.force_5     <= f_all[5];
          out_rsp_q.dissipative <= allzero_q || (!dot_q[DOT_W-1] && (|dot_q));
        end
      end
      default: ;
    endcase
  end

  // axes beyond DOF give zero force
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (a < DOF) begin
        f_all[a] = f_q[a];
      end else begin
        f_all[a] = '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== rtl/lqdf_checker.sv =====
// port-level checker for the damping force block and its bind
`include "assert_macros.svh"

module lqdf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input lqdf_pkg::in_req_t   in_req_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lqdf_pkg::out_rsp_t  out_rsp_o
);
  import lqdf_pkg::*;

  // stalled result holds
  `LQDF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o), "result changed while stalled")

  // evaluate request makes the block busy
  `LQDF_ASSERT(a_eval_busy, in_valid_i && in_ready_o && (in_req_i.opcode == OP_EVAL) |=> !in_ready_o, "ready after evaluate request")

  // other requests leave the block ready
  `LQDF_ASSERT(a_write_ready, in_valid_i && in_ready_o && (in_req_i.opcode != OP_EVAL) |=> in_ready_o, "not ready after write request")

  // no result right after any accepted request
  `LQDF_ASSERT_NEVER(a_no_early_out, $rose(out_valid_o) && $past(in_valid_i && in_ready_o), "result too early")

endmodule

bind linear_quadratic_damping_force lqdf_checker u_lqdf_checker (.*);
